// File: src/rtoe_pkg.sv
// Shared types, codes and helpers for the retransmit timeout estimator.
// Used by rtoe_core and retransmit_timeout_estimator_top; depends on nothing.
`timescale 1ns / 1ps

package rtoe_pkg;

   // Operation codes carried in the func field.
   localparam logic [1:0] FUNC_START   = 2'd0;
   localparam logic [1:0] FUNC_SAMPLE  = 2'd1;
   localparam logic [1:0] FUNC_TIMEOUT = 2'd2;
   localparam logic [1:0] FUNC_RESET   = 2'd3;

   // Configuration register indexes.
   localparam logic [1:0] CSR_RTO_MIN         = 2'd0;
   localparam logic [1:0] CSR_RTO_MAX         = 2'd1;
   localparam logic [1:0] CSR_MAX_RETRANSMITS = 2'd2;

   // Reset values and saturation limits.
   localparam logic [15:0] RTO_MIN_RESET         = 16'd1000;
   localparam logic [15:0] RTO_MAX_RESET         = 16'd3000;
   localparam logic [3:0]  MAX_RETRANSMITS_RESET = 4'd12;
   localparam logic [19:0] INIT_VAR              = 20'd3000;
   localparam logic [15:0] INIT_RTO              = 16'd3000;
   localparam logic [19:0] EST_MAX               = 20'hFFFFF;
   localparam logic [3:0]  COUNT_MAX             = 4'd15;

   typedef struct packed {
      logic [1:0]  func;
      logic [15:0] sample_ms;
      logic [3:0]  send_count;
   } req_type;

   typedef struct packed {
      logic [15:0] rto_ms;
      logic        gave_up;
      logic [3:0]  next_count;
   } rsp_type;

   typedef struct packed {
      logic [15:0] rto_min;
      logic [15:0] rto_max;
      logic [3:0]  max_retransmits;
   } cfg_type;

   // Clamp a timeout to the configured limits; the lower limit is tested first.
   function automatic logic [15:0] clamp_rto(input logic [20:0] value, input cfg_type cfg);
      logic [15:0] result;
      if (value < {5'd0, cfg.rto_min}) begin
         result = cfg.rto_min;
      end else if (value > {5'd0, cfg.rto_max}) begin
         result = cfg.rto_max;
      end else begin
         result = value[15:0];
      end
      return result;
   endfunction

endpackage

// File: src/rtoe_core.sv
// Estimator state and the single-pass update for one request beat.
// Depends on rtoe_pkg for the payload, configuration types and clamp helper.
`timescale 1ns / 1ps

module rtoe_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             step_en,
   input  rtoe_pkg::req_type req,
   input  rtoe_pkg::cfg_type cfg,
   output rtoe_pkg::rsp_type rsp
);

   logic [19:0] srtt_ff, srtt_in;
   logic [19:0] rttvar_ff, rttvar_in;
   logic [15:0] cur_rto_ff, cur_rto_in;
   logic [15:0] saved_rto_ff, saved_rto_in;

   logic [16:0] base;
   logic [16:0] ms_ext;
   logic        ms_ge;
   logic [16:0] mag;
   logic [20:0] srtt_sum;
   logic [19:0] srtt_upd;
   logic [20:0] var_sum;
   logic [19:0] var_upd;
   logic [20:0] rto_sum;
   logic [3:0]  count_inc;
   logic        give_up;

   // Sample path: error magnitude against the smoothed estimate.
   assign base   = srtt_ff[19:3];
   assign ms_ext = {1'b0, req.sample_ms};
   assign ms_ge  = ms_ext >= base;
   assign mag    = ms_ge ? (ms_ext - base) : (base - ms_ext);

   // Smoothed RTT x8 moves by the full error; it saturates on the way up.
   assign srtt_sum = {1'b0, srtt_ff} + {4'd0, mag};
   always_comb begin
      if (ms_ge) begin
         srtt_upd = srtt_sum[20] ? rtoe_pkg::EST_MAX : srtt_sum[19:0];
      end else begin
         srtt_upd = srtt_ff - {3'd0, mag};
      end
   end

   // Variance decays by a quarter and adds the error magnitude.
   assign var_sum = {1'b0, rttvar_ff - {2'd0, rttvar_ff[19:2]}} + {4'd0, mag};
   assign var_upd = var_sum[20] ? rtoe_pkg::EST_MAX : var_sum[19:0];
   assign rto_sum = {4'd0, srtt_upd[19:3]} + {1'b0, var_upd};

   // Timer path: saturating count and give-up test.
   assign count_inc = (req.send_count == rtoe_pkg::COUNT_MAX) ? rtoe_pkg::COUNT_MAX
                                                              : req.send_count + 4'd1;
   assign give_up   = count_inc >= cfg.max_retransmits;

   // Next state and result for the current beat.
   always_comb begin
      srtt_in        = srtt_ff;
      rttvar_in      = rttvar_ff;
      cur_rto_in     = cur_rto_ff;
      saved_rto_in   = saved_rto_ff;
      rsp.gave_up    = 1'b0;
      rsp.next_count = req.send_count;
      case (req.func)
         rtoe_pkg::FUNC_START: begin
            if (req.send_count == 4'd0) begin
               saved_rto_in = cur_rto_ff;
            end
         end
         rtoe_pkg::FUNC_SAMPLE: begin
            if (req.send_count != 4'd0) begin
               // Karn's rule: a retransmitted packet gives no valid sample.
               cur_rto_in = saved_rto_ff;
            end else begin
               srtt_in    = srtt_upd;
               rttvar_in  = var_upd;
               cur_rto_in = rtoe_pkg::clamp_rto(rto_sum, cfg);
            end
         end
         rtoe_pkg::FUNC_TIMEOUT: begin
            rsp.next_count = count_inc;
            if (give_up) begin
               rsp.gave_up = 1'b1;
            end else begin
               cur_rto_in = rtoe_pkg::clamp_rto({4'd0, cur_rto_ff, 1'b0}, cfg);
            end
         end
         rtoe_pkg::FUNC_RESET: begin
            srtt_in        = 20'd0;
            rttvar_in      = rtoe_pkg::INIT_VAR;
            cur_rto_in     = rtoe_pkg::clamp_rto({5'd0, rtoe_pkg::INIT_RTO}, cfg);
            saved_rto_in   = rtoe_pkg::clamp_rto({5'd0, rtoe_pkg::INIT_RTO}, cfg);
            rsp.next_count = 4'd0;
         end
         default: begin
            srtt_in = srtt_ff;
         end
      endcase
      rsp.rto_ms = cur_rto_in;
   end

   // Estimator state advances once per processed beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         srtt_ff      <= 20'd0;
         rttvar_ff    <= rtoe_pkg::INIT_VAR;
         cur_rto_ff   <= rtoe_pkg::INIT_RTO;
         saved_rto_ff <= rtoe_pkg::INIT_RTO;
      end else if (step_en) begin
         srtt_ff      <= srtt_in;
         rttvar_ff    <= rttvar_in;
         cur_rto_ff   <= cur_rto_in;
         saved_rto_ff <= saved_rto_in;
      end
   end

endmodule

// File: src/retransmit_timeout_estimator_top.sv
// Top level of the retransmit timeout estimator: handshakes, CSRs, result register.
// Depends on rtoe_pkg and rtoe_core.
`timescale 1ns / 1ps

// Usage:
// A request beat (req_data: func, sample_ms, send_count) is taken when req_valid
// and req_ready are both high. Each request yields exactly one response beat
// (rsp_data: rto_ms, gave_up, next_count), in order, taken when rsp_valid and
// rsp_ready are both high.
// The request lands in an input register; the estimator update runs in one
// pass from that register into the response register, which presents the
// response. One request per cycle is sustained while rsp_ready stays high;
// the rate is set by the estimator state registers, which are read and
// written once per beat.
// When the receiver stalls, the input register holds one more request and
// req_ready drops only once both registers are full.
// CSRs (rto_min, rto_max, max_retransmits) are written with csr_we, csr_index
// and csr_wdata while the block is idle, a rule for the user that the block
// does not enforce; index 3 is ignored. Synchronous reset empties both
// registers, loads the CSR defaults (1000, 3000, 12) and restores the
// estimates (srtt 0, variance 3000, timeout 3000). There is no clearing pass.
module retransmit_timeout_estimator_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rtoe_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rtoe_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_wdata
);

   rtoe_pkg::cfg_type cfg_ff;
   rtoe_pkg::req_type req_ff;
   logic              req_valid_ff, req_valid_in;
   rtoe_pkg::rsp_type rsp_data_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   rtoe_pkg::rsp_type core_rsp;
   logic              step_en;
   logic              req_take;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rto_min         <= rtoe_pkg::RTO_MIN_RESET;
         cfg_ff.rto_max         <= rtoe_pkg::RTO_MAX_RESET;
         cfg_ff.max_retransmits <= rtoe_pkg::MAX_RETRANSMITS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            rtoe_pkg::CSR_RTO_MIN:         cfg_ff.rto_min <= csr_wdata;
            rtoe_pkg::CSR_RTO_MAX:         cfg_ff.rto_max <= csr_wdata;
            rtoe_pkg::CSR_MAX_RETRANSMITS: cfg_ff.max_retransmits <= csr_wdata[3:0];
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

   // The held request moves on when the response register is free or draining.
   assign step_en   = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || step_en;
   assign req_take  = req_valid && req_ready;

   assign req_valid_in = req_take || (req_valid_ff && !step_en);
   assign rsp_valid_in = step_en || (rsp_valid_ff && !rsp_ready);

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
      end
      if (req_take) begin
         req_ff <= req_data;
      end
   end

   rtoe_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .req     (req_ff),
      .cfg     (cfg_ff),
      .rsp     (core_rsp)
   );

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (step_en) begin
         rsp_data_ff <= core_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // An accepted request is always held for processing in the next cycle.
   a_take_held: assert property (@(posedge clock) disable iff (reset)
      req_take |=> req_valid_ff)
      else $error("accepted request beat not held in input register");

   // A stalled response keeps the held request in place.
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      req_valid_ff && rsp_valid_ff && !rsp_ready |=> req_valid_ff && $stable(req_ff))
      else $error("held request changed while response stalled");

   // Give-up is only reported with a nonzero count.
   a_give_up_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.gave_up |-> rsp_data_ff.next_count != 4'd0)
      else $error("give-up reported with zero send count");

   // Ready low means both stages are occupied.
   a_ready_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> req_valid_ff && rsp_valid_ff)
      else $error("request stalled with a free stage");

endmodule

// File: dv/retransmit_timeout_estimator_top_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for retransmit_timeout_estimator_top: request beats go in
// through a valid/ready driver, every response is predicted on acceptance and checked in order.
// Depends on rtoe_pkg and the retransmit_timeout_estimator_top RTL.

module retransmit_timeout_estimator_top_test;
   import rtoe_pkg::*;

   localparam int unsigned WATCHDOG_LIMIT = 4000;
   localparam int unsigned HOLD_CYCLES    = 300;
   localparam int unsigned REPORT_LIMIT   = 10;
   localparam int unsigned RANDOM_PHASES  = 8;
   localparam int unsigned PHASE_ITEMS    = 118;
   localparam logic [1:0]  CSR_UNUSED     = 2'd3;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data  = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_we    = 1'b0;
   logic [1:0]  csr_index = CSR_RTO_MIN;
   logic [15:0] csr_wdata = '0;

   retransmit_timeout_estimator_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // 10 ns clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow copy of the limits and of the estimator state.
   cfg_type     lim_cfg;
   logic [19:0] est_srtt_x8;
   logic [19:0] est_var_x4;
   logic [15:0] est_rto;
   logic [15:0] est_saved_rto;

   req_type     req_pending_q[$];
   rsp_type     expected_rsp_q[$];
   int unsigned queued_cnt   = 0;
   int unsigned mismatch_cnt = 0;
   bit          idle_on      = 1'b0;
   bit          hold_request = 1'b0;

   // Limit a timeout to the configured range; if crossed, the lower bound wins only under it.
   function automatic logic [15:0] bound_rto(input int unsigned v);
      if (v < lim_cfg.rto_min) return lim_cfg.rto_min;
      if (v > lim_cfg.rto_max) return lim_cfg.rto_max;
      return v[15:0];
   endfunction

   function automatic logic [19:0] sat_est(input int unsigned v);
      return (v > EST_MAX) ? EST_MAX : v[19:0];
   endfunction

   function automatic void reset_estimates();
      est_srtt_x8   = '0;
      est_var_x4    = INIT_VAR;
      est_rto       = bound_rto(int'(INIT_VAR));
      est_saved_rto = est_rto;
   endfunction

   // Work out the response to one accepted request and advance the shadow state.
   function automatic rsp_type predict_rsp(input req_type req);
      rsp_type     r;
      int unsigned base;
      int unsigned mag;
      int unsigned acc;
      int unsigned cnt;
      logic        gave;
      cnt  = req.send_count;
      gave = 1'b0;
      case (req.func)
         FUNC_START: begin
            if (req.send_count == 4'd0) est_saved_rto = est_rto;
         end
         FUNC_SAMPLE: begin
            if (cnt != 0) begin
               // Karn's rule: a retransmitted packet gives no usable sample.
               est_rto = est_saved_rto;
            end else begin
               base = est_srtt_x8 >> 3;
               if (req.sample_ms >= base) begin
                  mag = req.sample_ms - base;
                  acc = est_srtt_x8 + mag;
                  est_srtt_x8 = sat_est(acc);
               end else begin
                  mag = base - req.sample_ms;
                  est_srtt_x8 = 20'(est_srtt_x8 - mag);
               end
               acc = est_var_x4;
               acc = acc - (acc >> 2) + mag;
               est_var_x4 = sat_est(acc);
               acc = est_srtt_x8 >> 3;
               est_rto = bound_rto(acc + est_var_x4);
            end
         end
         FUNC_TIMEOUT: begin
            if (cnt < 15) cnt++;
            if (cnt >= lim_cfg.max_retransmits) begin
               gave = 1'b1;
            end else begin
               acc = est_rto;
               est_rto = bound_rto(acc * 2);
            end
         end
         FUNC_RESET: begin
            reset_estimates();
            cnt = 0;
         end
         default: begin
         end
      endcase
      r.rto_ms     = est_rto;
      r.gave_up    = gave;
      r.next_count = cnt[3:0];
      return r;
   endfunction

   // Gap length for either side: mostly none or short, now and then long.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic note_error(input string msg);
      if (mismatch_cnt < REPORT_LIMIT) $display("%0t: %s", $time, msg);
      mismatch_cnt++;
   endtask

   task automatic check_rsp(input rsp_type got);
      rsp_type want;
      if (expected_rsp_q.size() == 0) begin
         note_error($sformatf("unexpected response rto_ms=%0d gave_up=%0d next_count=%0d",
                              got.rto_ms, got.gave_up, got.next_count));
      end else begin
         want = expected_rsp_q.pop_front();
         if (got.rto_ms !== want.rto_ms || got.gave_up !== want.gave_up ||
             got.next_count !== want.next_count) begin
            note_error($sformatf({"response mismatch: expected rto_ms=%0d gave_up=%0d ",
                                  "next_count=%0d, got rto_ms=%0d gave_up=%0d next_count=%0d"},
                                 want.rto_ms, want.gave_up, want.next_count,
                                 got.rto_ms, got.gave_up, got.next_count));
         end
      end
   endtask

   // Request driver: predicts each accepted beat, then offers the next pending one.
   int unsigned send_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_rsp_q.push_back(predict_rsp(req_data));
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (req_pending_q.size() > 0) begin
               req_data  <= req_pending_q.pop_front();
               req_valid <= 1'b1;
               send_gap = idle_on ? pick_gap() : 0;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: checks each accepted beat and paces rsp_ready.
   int unsigned ready_gap = 0;
   int unsigned hold_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) check_rsp(rsp_data);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (ready_gap > 0) begin
            ready_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (idle_on && $urandom_range(0, 3) == 0) ready_gap = pick_gap();
         end
      end
   end

   // Watchdog: counts cycles with work outstanding but no beat on either side.
   int unsigned quiet_cycles = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (!req_valid && req_pending_q.size() == 0 && expected_rsp_q.size() == 0)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   task automatic queue_req(input logic [1:0] func, input logic [15:0] ms,
                            input logic [3:0] cnt);
      req_type item;
      item.func       = func;
      item.sample_ms  = ms;
      item.send_count = cnt;
      req_pending_q.push_back(item);
      queued_cnt++;
   endtask

   function automatic logic [15:0] pick_rtt_ms();
      int unsigned r;
      logic [15:0] ms;
      r = $urandom_range(0, 99);
      if (r < 55) ms = 16'($urandom_range(20, 3000));
      else if (r < 70) ms = 16'($urandom_range(0, 40));
      else ms = 16'($urandom());
      return ms;
   endfunction

   // One packet's life: first send, some timer expiries, then the echoed sample.
   task automatic queue_send_episode();
      int unsigned tries;
      int unsigned i;
      logic [3:0]  cnt;
      tries = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 15) : $urandom_range(0, 3);
      queue_req(FUNC_START, 16'($urandom()), 4'd0);
      for (i = 0; i < tries; i++) begin
         cnt = 4'(i);
         queue_req(FUNC_TIMEOUT, 16'($urandom()), cnt);
         if ($urandom_range(0, 7) == 0) begin
            cnt = 4'(i + 1);
            queue_req(FUNC_START, 16'($urandom()), cnt);
         end
      end
      cnt = 4'(tries);
      queue_req(FUNC_SAMPLE, pick_rtt_ms(), cnt);
   endtask

   // A beat with arbitrary fields; the reset operation is kept rare.
   task automatic queue_noise();
      int unsigned r;
      logic [1:0]  func;
      r = $urandom_range(0, 19);
      if (r == 0) func = FUNC_RESET;
      else if (r % 3 == 0) func = FUNC_START;
      else if (r % 3 == 1) func = FUNC_SAMPLE;
      else func = FUNC_TIMEOUT;
      queue_req(func, 16'($urandom()), 4'($urandom()));
   endtask

   task automatic wait_idle();
      while (req_pending_q.size() != 0 || req_valid || expected_rsp_q.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [15:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_RTO_MIN:         lim_cfg.rto_min = val;
         CSR_RTO_MAX:         lim_cfg.rto_max = val;
         CSR_MAX_RETRANSMITS: lim_cfg.max_retransmits = val[3:0];
         default: ;
      endcase
   endtask

   task automatic set_limits(input logic [15:0] lo, input logic [15:0] hi,
                             input logic [15:0] retr);
      write_csr(CSR_RTO_MIN, lo);
      write_csr(CSR_RTO_MAX, hi);
      write_csr(CSR_MAX_RETRANSMITS, retr);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_random_limits();
      logic [15:0] lo;
      logic [15:0] hi;
      logic [15:0] retr;
      if ($urandom_range(0, 4) == 0) begin
         // Crossed limits.
         lo = 16'($urandom_range(2000, 65535));
         hi = 16'($urandom_range(1, lo - 1));
      end else begin
         lo = 16'($urandom_range(1, 2500));
         hi = 16'($urandom_range(lo, 65535));
      end
      retr = 16'($urandom());
      retr[3:0] = 4'($urandom_range(0, 15));
      set_limits(lo, hi, retr);
   endtask

   task automatic run_random_phase(input bit with_idle, input bit with_hold);
      int unsigned first;
      idle_on = with_idle;
      if (with_hold) hold_request = 1'b1;
      first = queued_cnt;
      while (queued_cnt - first < PHASE_ITEMS) begin
         if ($urandom_range(0, 3) == 0) queue_noise();
         else queue_send_episode();
      end
      wait_idle();
   endtask

   initial begin
      int unsigned p;
      lim_cfg.rto_min         = RTO_MIN_RESET;
      lim_cfg.rto_max         = RTO_MAX_RESET;
      lim_cfg.max_retransmits = MAX_RETRANSMITS_RESET;
      reset_estimates();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Reset defaults: save, update, Karn restore, doubling, give-up, saturation.
      queue_req(FUNC_START,   16'hFFFF, 4'd0);
      queue_req(FUNC_SAMPLE,  16'd0,    4'd0);
      queue_req(FUNC_SAMPLE,  16'hFFFF, 4'd0);
      queue_req(FUNC_SAMPLE,  16'd1234, 4'd15);
      queue_req(FUNC_TIMEOUT, 16'd0,    4'd0);
      queue_req(FUNC_TIMEOUT, 16'd0,    4'd10);
      queue_req(FUNC_TIMEOUT, 16'd0,    4'd11);
      queue_req(FUNC_TIMEOUT, 16'hAAAA, 4'd15);
      queue_req(FUNC_START,   16'h5555, 4'd7);
      queue_req(FUNC_SAMPLE,  16'd500,  4'd2);
      queue_req(FUNC_RESET,   16'hFFFF, 4'd15);
      queue_req(FUNC_SAMPLE,  16'd1,    4'd0);
      wait_idle();

      // Widest limits: large samples and doubling run into the upper bound.
      set_limits(16'd1, 16'hFFFF, 16'd15);
      queue_req(FUNC_START,   16'd0,    4'd0);
      queue_req(FUNC_SAMPLE,  16'hFFFF, 4'd0);
      queue_req(FUNC_SAMPLE,  16'hFFFF, 4'd0);
      queue_req(FUNC_SAMPLE,  16'hFFFF, 4'd0);
      queue_req(FUNC_TIMEOUT, 16'd0,    4'd3);
      queue_req(FUNC_TIMEOUT, 16'd0,    4'd14);
      queue_req(FUNC_SAMPLE,  16'd0,    4'd0);
      wait_idle();

      // A zero retransmit limit gives up on every timeout.
      set_limits(16'd200, 16'd60000, 16'd0);
      queue_req(FUNC_TIMEOUT, 16'd0,    4'd0);
      queue_req(FUNC_SAMPLE,  16'd100,  4'd0);
      wait_idle();

      // Crossed limits; the unused register index is written too and must be ignored.
      write_csr(CSR_UNUSED, 16'hFFFF);
      set_limits(16'd5000, 16'd200, 16'd5);
      queue_req(FUNC_RESET,   16'd0,    4'd0);
      queue_req(FUNC_SAMPLE,  16'd3000, 4'd0);
      queue_req(FUNC_TIMEOUT, 16'd0,    4'd1);
      queue_req(FUNC_START,   16'd0,    4'd0);
      wait_idle();

      // Random phases, each under its own limits.
      for (p = 0; p < RANDOM_PHASES; p++) begin
         if (p == 1) set_limits(16'hFFFF, 16'hFFFF, 16'd1);
         else if (p == RANDOM_PHASES - 1)
            set_limits(RTO_MIN_RESET, RTO_MAX_RESET, {12'd0, MAX_RETRANSMITS_RESET});
         else set_random_limits();
         run_random_phase(p != 0, p == 0 || p == 3);
      end

      wait_idle();
      repeat (8) @(posedge clock);
      if (mismatch_cnt == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule
